// ----- rtl/core/itp_pkg.sv -----
// Package for the infix to postfix converter core.
// Token, result and error codes, sequencer states, precedence function.
// No dependencies.
package itp_pkg;

	localparam int DEF_STACK_DEPTH   = 32;
	localparam int DEF_OPERAND_WIDTH = 32;

	typedef enum logic [3:0] {
		TK_OPERAND = 4'd0,
		TK_PLUS    = 4'd1,
		TK_MINUS   = 4'd2,
		TK_TIMES   = 4'd3,
		TK_DIVIDE  = 4'd4,
		TK_POWER   = 4'd5,
		TK_OPEN    = 4'd6,
		TK_CLOSE   = 4'd7,
		TK_END     = 4'd8
	} token_kind_t;

	typedef enum logic [2:0] {
		OK_OPERAND = 3'd0,
		OK_PLUS    = 3'd1,
		OK_MINUS   = 3'd2,
		OK_TIMES   = 3'd3,
		OK_DIVIDE  = 3'd4,
		OK_POWER   = 3'd5,
		OK_END     = 3'd6
	} out_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_CLOSE    = 2'd2,
		ERR_OPEN     = 2'd3
	} error_t;

	// Stack entries hold operator codes 1..5 and this code for '('.
	localparam logic [2:0] CODE_OPEN = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic        emit;
		logic        flush;
		logic        take_value;
		logic [2:0]  kind;
		error_t      err;
	} emit_req_t;

	typedef struct packed {
		logic emit_ok;
		logic flush_done;
	} out_status_t;

	function automatic logic [1:0] prec(input logic [2:0] code);
		logic [1:0] p;
		p = 2'd0;
		if (code == 3'd1 || code == 3'd2) p = 2'd1;
		else if (code == 3'd3 || code == 3'd4) p = 2'd2;
		else if (code == 3'd5) p = 2'd3;
		return p;
	endfunction

endpackage

// ----- rtl/core/itp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/itp_out.sv -----
// Result staging: a pending register that waits to learn whether its result
// is the last one of the request, and the output register. Uses itp_pkg.
module itp_out
	import itp_pkg::*;
#(
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  emit_req_t                req,
	input  logic [OPERAND_WIDTH-1:0] operand_value,
	output out_status_t              status,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [2:0]               out_kind,
	output logic [OPERAND_WIDTH-1:0] out_value,
	output logic                     last,
	output logic [1:0]               error
);

	logic                     pend_v_q;
	logic [2:0]               pend_kind_q;
	logic [OPERAND_WIDTH-1:0] pend_value_q;
	error_t                   pend_err_q;
	logic                     out_free;
	logic                     do_emit;
	logic                     do_flush;

	assign out_free          = !result_valid || !result_stall;
	assign status.emit_ok    = !pend_v_q || out_free;
	assign status.flush_done = !pend_v_q || out_free;
	assign do_emit           = req.emit && status.emit_ok;
	assign do_flush          = req.flush && pend_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (do_emit) pend_v_q <= 1'b1;
			else if (do_flush) pend_v_q <= 1'b0;
			if ((do_emit && pend_v_q) || do_flush) result_valid <= 1'b1;
			else if (out_free) result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			pend_kind_q  <= req.kind;
			pend_err_q   <= req.err;
			pend_value_q <= req.take_value ? operand_value : '0;
			if (pend_v_q) begin
				out_kind  <= pend_kind_q;
				out_value <= pend_value_q;
				error     <= pend_err_q;
				last      <= 1'b0;
			end
		end else if (do_flush) begin
			out_kind  <= pend_kind_q;
			out_value <= pend_value_q;
			error     <= pend_err_q;
			last      <= 1'b1;
		end
	end

	a_emit_flush_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.emit && req.flush))
		else $error("emit and flush requested together");

	a_emit_shift_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(do_emit && pend_v_q) |=> (result_valid && !last))
		else $error("displaced pending result not shown as non-last");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		do_flush |=> (result_valid && last && !pend_v_q))
		else $error("flushed result not marked last");

endmodule

// ----- rtl/core/itp_ctrl.sv -----
// Sequencer for the operator stack: pops, pushes and result requests.
// Uses itp_pkg and one itp_ram instance for the stack.
module itp_ctrl
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        token_valid,
	output logic        token_stall,
	input  logic [3:0]  token_kind,
	input  out_status_t status,
	output emit_req_t   req
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t        state_q, state_d;
	logic [3:0]    kind_q;
	logic [CW-1:0] count_q;
	logic          open_seen_q;
	logic [2:0]    top;
	logic          empty;
	logic          full;
	logic          ram_re, ram_we;
	logic          pop, push, set_open;
	logic          accept;
	logic          top_wins;
	logic [CW-1:0] count_m1;

	assign accept   = token_valid && (state_q == ST_IDLE);
	assign empty    = (count_q == '0);
	assign full     = (count_q >= CW'(STACK_DEPTH));
	assign count_m1 = count_q - 1'b1;
	assign top_wins = prec(top) >= prec(kind_q[2:0]);

	itp_ram #(
		.WIDTH(3),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(kind_q[2:0]),
		.re   (ram_re),
		.raddr(count_m1[AW-1:0]),
		.rdata(top)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (token_valid) begin
					priority case (token_kind)
						TK_OPERAND: state_d = ST_FLUSH;
						TK_PLUS, TK_MINUS, TK_TIMES, TK_DIVIDE, TK_CLOSE, TK_END:
							state_d = ST_READ;
						TK_POWER, TK_OPEN: state_d = ST_PUSH;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_DECIDE;
			ST_DECIDE: begin
				priority case (kind_q)
					TK_CLOSE: begin
						if (empty) begin
							if (status.emit_ok) state_d = ST_FLUSH;
						end else if (top == CODE_OPEN) state_d = ST_FLUSH;
						else if (status.emit_ok) state_d = ST_READ;
					end
					TK_END: begin
						if (empty) begin
							if (status.emit_ok) state_d = ST_FLUSH;
						end else if (top == CODE_OPEN) state_d = ST_READ;
						else if (status.emit_ok) state_d = ST_READ;
					end
					default: begin
						if (empty || !top_wins) state_d = ST_PUSH;
						else if (status.emit_ok) state_d = ST_READ;
					end
				endcase
			end
			ST_PUSH: begin
				if (!full || status.emit_ok) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (status.flush_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.emit       = 1'b0;
		req.flush      = 1'b0;
		req.take_value = 1'b0;
		req.kind       = OK_OPERAND;
		req.err        = ERR_NONE;
		ram_re         = 1'b0;
		ram_we         = 1'b0;
		pop            = 1'b0;
		push           = 1'b0;
		set_open       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (token_valid && token_kind == TK_OPERAND) begin
					req.emit       = 1'b1;
					req.take_value = 1'b1;
				end
			end
			ST_READ: ram_re = 1'b1;
			ST_DECIDE: begin
				priority case (kind_q)
					TK_CLOSE: begin
						if (empty) begin
							req.emit = 1'b1;
							req.err  = ERR_CLOSE;
						end else if (top == CODE_OPEN) begin
							pop = 1'b1;
						end else begin
							req.emit = 1'b1;
							req.kind = top;
							pop      = status.emit_ok;
						end
					end
					TK_END: begin
						if (empty) begin
							req.emit = 1'b1;
							req.kind = OK_END;
							req.err  = open_seen_q ? ERR_OPEN : ERR_NONE;
						end else if (top == CODE_OPEN) begin
							pop      = 1'b1;
							set_open = 1'b1;
						end else begin
							req.emit = 1'b1;
							req.kind = top;
							pop      = status.emit_ok;
						end
					end
					default: begin
						if (!empty && top_wins) begin
							req.emit = 1'b1;
							req.kind = top;
							pop      = status.emit_ok;
						end
					end
				endcase
			end
			ST_PUSH: begin
				if (!full) begin
					ram_we = 1'b1;
					push   = 1'b1;
				end else begin
					req.emit = 1'b1;
					req.err  = ERR_OVERFLOW;
				end
			end
			ST_FLUSH: req.flush = 1'b1;
			default: ;
		endcase
	end

	assign token_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			open_seen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) count_q <= count_q + 1'b1;
			else if (pop) count_q <= count_m1;
			if (accept) open_seen_q <= 1'b0;
			else if (set_open) open_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) kind_q <= token_kind;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !full)
		else $error("stack write while full");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
		|| (count_q == $past(count_q) - 1'b1))
		else $error("stack count moved by more than one");

endmodule

// ----- rtl/core/infix_to_postfix_converter_core.sv -----
// Shunting-yard infix to postfix converter: one token in, postfix results out.
// Token channel: token_valid/token_stall with token_kind and operand_value.
// Result channel: result_valid/result_stall with out_kind, out_value, last
// and error; last marks the final result of a token, error flags stack
// overflow, an unmatched ')' or a '(' left at the end token.
// A token is taken only while the sequencer is idle; token_stall is high
// while a token is worked on. An operand is placed in the pending register
// when taken and released as the last result of its token. An operator,
// ')' or end token is taken, then each stack entry is examined by a stack
// RAM read and then a compare (an empty stack is examined once too), then
// an operator is pushed and the last result is released; '^' and '(' are
// pushed without examining the stack.
// The stack lives in a single-port-read RAM, so one entry is popped at a time.
// Results pass a pending register and an output register; on a receiver stall
// the output holds and, with a result pending, the sequencer waits to emit.
// Reset (arst_n low) empties the stack count and drops any held result; the
// stack RAM is not cleared, as only written entries are ever read.
// Uses itp_pkg, itp_ctrl, itp_out and itp_ram.
module infix_to_postfix_converter_core
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     token_valid,
	output logic                     token_stall,
	input  logic [3:0]               token_kind,
	input  logic [OPERAND_WIDTH-1:0] operand_value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [2:0]               out_kind,
	output logic [OPERAND_WIDTH-1:0] out_value,
	output logic                     last,
	output logic [1:0]               error
);

	emit_req_t   req;
	out_status_t status;

	itp_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind (token_kind),
		.status     (status),
		.req        (req)
	);

	itp_out #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.operand_value(operand_value),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_kind     (out_kind),
		.out_value    (out_value),
		.last         (last),
		.error        (error)
	);

endmodule
